FILE: rtl/crlf_pkg.sv
// Shared types and constants for the CR LF line receiver.
// No dependencies; used by crlf_line_ctrl and crlf_line_receiver_unit.
package crlf_pkg;

   localparam int LINE_DEPTH_DEF = 256;

   localparam logic [7:0] BYTE_CR = 8'h0d;
   localparam logic [7:0] BYTE_LF = 8'h0a;

   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic       line_done;
      logic       cr_pending;
      logic [7:0] line_length;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      logic       line_done;
      logic       cr_pending;
      logic [7:0] line_length;
   } status_type;

   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] wr_data;
   } mem_ctl_type;

endpackage

FILE: rtl/crlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/crlf_line_ctrl.sv
// Line state (flags, byte count) and line store access control.
// Depends on crlf_pkg.
module crlf_line_ctrl #(
   parameter int LINE_DEPTH = crlf_pkg::LINE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  crlf_pkg::req_type             req,
   output crlf_pkg::mem_ctl_type         mem_ctl,
   output logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
   output logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
   output crlf_pkg::status_type          status_in
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam logic [AW-1:0] CNT_LAST = AW'(LINE_DEPTH - 1);

   logic          done_ff, done_in;
   logic          cr_ff, cr_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW+7:0] idx_wide;
   logic [AW+7:0] cnt_wide;
   logic          idx_in_range;

   assign idx_wide     = (AW + 8)'(req.read_index);
   assign idx_in_range = idx_wide < (AW + 8)'(LINE_DEPTH);
   assign rd_addr      = idx_wide[AW-1:0];
   assign wr_addr      = cnt_ff;

   always_comb begin
      done_in         = done_ff;
      cr_in           = cr_ff;
      cnt_in          = cnt_ff;
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.rd_en   = 1'b0;
      mem_ctl.wr_data = req.rx_byte;
      if (accept) begin
         unique case (req.cmd)
            crlf_pkg::CMD_BYTE: begin
               if (!done_ff) begin
                  if (cr_ff) begin
                     if (req.rx_byte == crlf_pkg::BYTE_LF) begin
                        done_in = 1'b1;
                     end else begin
                        cr_in  = 1'b0;
                        cnt_in = '0;
                     end
                  end else if (req.rx_byte == crlf_pkg::BYTE_CR) begin
                     cr_in = 1'b1;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     // restart the line when the store fills
                     if (cnt_ff == CNT_LAST) begin
                        cnt_in = '0;
                     end else begin
                        cnt_in = cnt_ff + AW'(1);
                     end
                  end
               end
            end
            crlf_pkg::CMD_CLEAR: begin
               done_in = 1'b0;
               cr_in   = 1'b0;
               cnt_in  = '0;
            end
            crlf_pkg::CMD_READ: begin
               mem_ctl.rd_en = idx_in_range;
            end
            crlf_pkg::CMD_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign cnt_wide              = (AW + 8)'(cnt_in);
   assign status_in.line_done   = done_in;
   assign status_in.cr_pending  = cr_in;
   assign status_in.line_length = cnt_wide[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         cr_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= done_in;
         cr_ff   <= cr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

FILE: rtl/crlf_line_receiver_unit.sv
// Top level of the CR LF line receiver: request/response pipeline around
// the line state controller and the line store RAM. Depends on crlf_pkg,
// crlf_line_ctrl and crlf_ram.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_ready | cmd, rx_byte, read_index
//   rsp     | out       | rsp_valid / rsp_ready | line_done, cr_pending,
//           |           |                       | line_length, read_byte
//
// One beat is accepted per cycle unless the response side stalls; each request
// beat yields one response beat (RAM read stage, then the output register).
// The single port pair of the line store sets the rate: one write or one read
// per beat. Reset clears the flags, the byte count and the pipeline valids;
// the store contents are left as they are and need no clearing pass.
// A stalled response holds the output register and, once stage 1 fills, drops req_ready; nothing is lost.
module crlf_line_receiver_unit #(
   parameter int LINE_DEPTH = crlf_pkg::LINE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crlf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crlf_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(LINE_DEPTH);

   logic                  accept;
   logic                  advance;
   logic                  move;
   crlf_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   crlf_pkg::status_type  status_in;
   logic [7:0]            ram_q;

   // stage 1: status after the update, waiting on RAM read data
   logic                  s1_valid_ff, s1_valid_in;
   crlf_pkg::status_type  s1_status_ff;
   logic                  s1_rd_use_ff;

   // stage 2: output register
   logic                  out_valid_ff, out_valid_in;
   crlf_pkg::rsp_type     out_data_ff;

   // advance stage 1 whenever the output register is free or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign move      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   crlf_line_ctrl #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .status_in (status_in)
   );

   // Write and read never share a beat, and a read issued the cycle after a
   // write sees the new data, so no forwarding is needed.
   crlf_ram #(
      .WIDTH(8),
      .DEPTH(LINE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on accept / move, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status_in;
         s1_rd_use_ff <= mem_ctl.rd_en;
      end
      if (move) begin
         out_data_ff.line_done   <= s1_status_ff.line_done;
         out_data_ff.cr_pending  <= s1_status_ff.cr_pending;
         out_data_ff.line_length <= s1_status_ff.line_length;
         out_data_ff.read_byte   <= s1_rd_use_ff ? ram_q : 8'h00;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
